/* hdl/quadrature_decoder_with_acceleration_macros.svh */
// Assertion macros shared by the quadrature decoder RTL.
// Assertions sample on aclk; QDEC_ASSERT ones are disabled while aresetn is low.
`ifndef QUADRATURE_DECODER_WITH_ACCELERATION_MACROS_SVH
`define QUADRATURE_DECODER_WITH_ACCELERATION_MACROS_SVH
`ifndef ASSERT_OFF
`define QDEC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define QDEC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define QDEC_ASSERT(lbl, prop, msg)
`define QDEC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hdl/qdec_pkg.sv */
// Package for the quadrature decoder: widths, codes, the state tables and
// the controller/datapath interface structs. No dependencies.
package qdec_pkg;

    localparam int TIME_W    = 32;
    localparam int GAP_W     = 16;
    localparam int MULT_W    = 8;
    localparam int STATE_W   = 3;
    localparam int COL_W     = 2;
    localparam int ENTRY_W   = 8;
    localparam int STEP_W    = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int DIVD_W    = GAP_W + MULT_W;
    localparam int DCNT_W    = 5;

    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIVD_W - 1);

    localparam logic [ENTRY_W-1:0] STATE_MASK = 8'h0F;
    localparam logic [ENTRY_W-1:0] DIR_MASK   = 8'h30;
    localparam logic [ENTRY_W-1:0] DIR_CW     = 8'h10;
    localparam logic [ENTRY_W-1:0] DIR_CCW    = 8'h20;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_EN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MULT  = 2'd3;

    localparam logic [ENTRY_W-1:0] FULL_TBL [0:6][0:3] = '{
        '{8'h00, 8'h02, 8'h04, 8'h00},
        '{8'h03, 8'h00, 8'h01, 8'h10},
        '{8'h03, 8'h02, 8'h00, 8'h00},
        '{8'h03, 8'h02, 8'h01, 8'h00},
        '{8'h06, 8'h00, 8'h04, 8'h00},
        '{8'h06, 8'h05, 8'h00, 8'h20},
        '{8'h06, 8'h05, 8'h04, 8'h00}
    };

    localparam logic [ENTRY_W-1:0] HALF_TBL [0:5][0:3] = '{
        '{8'h03, 8'h02, 8'h01, 8'h00},
        '{8'h23, 8'h00, 8'h01, 8'h00},
        '{8'h13, 8'h02, 8'h00, 8'h00},
        '{8'h03, 8'h05, 8'h04, 8'h00},
        '{8'h03, 8'h03, 8'h04, 8'h10},
        '{8'h03, 8'h05, 8'h03, 8'h20}
    };

    typedef struct packed {
        logic accept;
        logic mul_load;
        logic div_step;
        logic fin;
        logic emit;
    } qdec_cmd_t;

    typedef struct packed {
        logic step;
        logic accel;
        logic div_last;
        logic out_free;
    } qdec_sts_t;

    // Rows that the selected table lacks fall back to the start state.
    function automatic logic [ENTRY_W-1:0] qdec_lookup(
        input logic               half,
        input logic [STATE_W-1:0] idx,
        input logic [COL_W-1:0]   col
    );
        logic [STATE_W-1:0] row;
        logic [ENTRY_W-1:0] entry;
        row = idx;
        if (half) begin
            if (idx >= 3'd6) begin
                row = '0;
            end
            entry = HALF_TBL[row][col];
        end else begin
            if (idx >= 3'd7) begin
                row = '0;
            end
            entry = FULL_TBL[row][col];
        end
        return entry;
    endfunction

endpackage

/* hdl/qdec_dp.sv */
// Datapath of the quadrature decoder: configuration, table state, step time,
// multiplier product, restoring divider and output register. Uses qdec_pkg.
`include "quadrature_decoder_with_acceleration_macros.svh"
module qdec_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [qdec_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qdec_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             s_a_level,
    input  logic                             s_b_level,
    input  logic [qdec_pkg::TIME_W-1:0]      s_now_ms,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [qdec_pkg::STEP_W-1:0] m_step_count,
    input  qdec_pkg::qdec_cmd_t              cmd,
    output qdec_pkg::qdec_sts_t              sts
);
    import qdec_pkg::*;

    logic                half_reg;
    logic                accel_en_reg;
    logic [GAP_W-1:0]    gap_reg;
    logic [MULT_W-1:0]   max_mult_reg;

    logic [STATE_W-1:0]  state_reg;
    logic [TIME_W-1:0]   last_step_time_reg;
    logic                step_reg;
    logic                accel_reg;
    logic                dir_cw_reg;
    logic [GAP_W-1:0]    interval_reg;
    logic [MULT_W-1:0]   mult_reg;

    logic [GAP_W-1:0]    divisor_reg;
    logic [GAP_W-1:0]    rem_reg;
    logic [DIVD_W-1:0]   quo_reg;
    logic [DCNT_W-1:0]   div_cnt_reg;

    logic                m_valid_reg;
    logic [STEP_W-1:0]   step_count_reg;

    logic [ENTRY_W-1:0]  entry_w;
    logic [ENTRY_W-1:0]  dir_w;
    logic                step_w;
    logic [TIME_W-1:0]   interval_w;
    logic                accel_w;
    logic [GAP_W-1:0]    diff_w;
    logic [DIVD_W-1:0]   prod_w;
    logic [GAP_W+1:0]    trial_w;
    logic [DIVD_W:0]     m_wide_w;
    logic [STEP_W-1:0]   mag_w;

    assign entry_w    = qdec_lookup(half_reg, state_reg, {s_a_level, s_b_level});
    assign dir_w      = entry_w & DIR_MASK;
    assign step_w     = (dir_w == DIR_CW) || (dir_w == DIR_CCW);
    assign interval_w = s_now_ms - last_step_time_reg;
    // A gap of one always gives a multiplier of one, so no division is needed.
    assign accel_w    = accel_en_reg && (last_step_time_reg != '0) &&
                        (interval_w < {{(TIME_W-GAP_W){1'b0}}, gap_reg}) &&
                        (gap_reg != 16'd1);

    assign diff_w   = gap_reg - interval_reg - 16'd1;
    assign prod_w   = {{MULT_W{1'b0}}, diff_w} * {{GAP_W{1'b0}}, max_mult_reg};
    assign trial_w  = {1'b0, rem_reg, quo_reg[DIVD_W-1]} - {2'b00, divisor_reg};
    assign m_wide_w = {1'b0, quo_reg} + (DIVD_W+1)'(1);
    assign mag_w    = {1'b0, mult_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg     <= 1'b0;
            accel_en_reg <= 1'b0;
            gap_reg      <= '0;
            max_mult_reg <= 8'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_HALF_STEP: half_reg     <= cfg_data[0];
                CFG_ACCEL_EN:  accel_en_reg <= cfg_data[0];
                CFG_GAP:       gap_reg      <= cfg_data[GAP_W-1:0];
                CFG_MAX_MULT:  max_mult_reg <= cfg_data[MULT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= '0;
            last_step_time_reg <= '0;
            step_reg           <= 1'b0;
            accel_reg          <= 1'b0;
        end else if (cmd.accept) begin
            state_reg <= entry_w[STATE_W-1:0] & STATE_MASK[STATE_W-1:0];
            step_reg  <= step_w;
            accel_reg <= accel_w;
            if (step_w) begin
                last_step_time_reg <= s_now_ms;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            dir_cw_reg   <= (dir_w == DIR_CW);
            interval_reg <= interval_w[GAP_W-1:0];
            mult_reg     <= 8'd1;
        end else if (cmd.fin) begin
            // The quotient never exceeds the maximum, so one more is clamped.
            if (m_wide_w > {{(DIVD_W+1-MULT_W){1'b0}}, max_mult_reg}) begin
                mult_reg <= max_mult_reg;
            end else begin
                mult_reg <= m_wide_w[MULT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_load) begin
            quo_reg     <= prod_w;
            rem_reg     <= '0;
            divisor_reg <= gap_reg - 16'd1;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + 5'd1;
            if (!trial_w[GAP_W+1]) begin
                rem_reg <= trial_w[GAP_W-1:0];
                quo_reg <= {quo_reg[DIVD_W-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[GAP_W-2:0], quo_reg[DIVD_W-1]};
                quo_reg <= {quo_reg[DIVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            step_count_reg <= dir_cw_reg ? mag_w : (~mag_w + 9'd1);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_step_count = $signed(step_count_reg);

    assign sts.step     = step_reg;
    assign sts.accel    = accel_reg;
    assign sts.div_last = (div_cnt_reg == DIV_LAST);
    assign sts.out_free = !m_valid_reg || m_ready;

    `QDEC_ASSERT(a_fin_clamped, cmd.fin |=> (mult_reg <= max_mult_reg), "multiplier above maximum")
    `QDEC_ASSERT(a_time_kept, (cmd.accept && !step_w) |=> $stable(last_step_time_reg), "step time moved without a step")
    `QDEC_ASSERT(a_emit_valid, cmd.emit |=> m_valid_reg, "emitted beat not presented")

endmodule

/* hdl/qdec_ctrl.sv */
// Controller of the quadrature decoder: sequences lookup, product, division
// and output of one sample at a time. Uses qdec_pkg.
`include "quadrature_decoder_with_acceleration_macros.svh"
module qdec_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  qdec_pkg::qdec_sts_t sts,
    output qdec_pkg::qdec_cmd_t cmd
);
    import qdec_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready      = (state_reg == S_IDLE);
    assign cmd.accept   = s_valid && s_ready;
    assign cmd.mul_load = (state_reg == S_MUL);
    assign cmd.div_step = (state_reg == S_DIV);
    assign cmd.fin      = (state_reg == S_FIN);
    assign cmd.emit     = (state_reg == S_EMIT) && sts.out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!sts.step) begin
                    state_next = S_IDLE;
                end else if (sts.accel) begin
                    state_next = S_MUL;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_MUL:  state_next = S_DIV;
            S_DIV: begin
                if (sts.div_last) begin
                    state_next = S_FIN;
                end
            end
            S_FIN:  state_next = S_EMIT;
            S_EMIT: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `QDEC_ASSERT(a_no_step_idle, (state_reg == S_EVAL && !sts.step) |=> (state_reg == S_IDLE), "sample without step did not return to idle")
    `QDEC_ASSERT(a_div_done, (state_reg == S_DIV && sts.div_last) |=> (state_reg == S_FIN), "division did not finish")
    `QDEC_ASSERT(a_emit_hold, (state_reg == S_EMIT && !sts.out_free) |=> (state_reg == S_EMIT), "result dropped while output busy")

endmodule

/* hdl/quadrature_decoder_with_acceleration.sv */
// Quadrature decoder with acceleration. An accepted sample that gives an accelerated
// step goes through the product and the one-bit-per-cycle restoring divider before
// its result beat; a plain step goes straight to it. A new sample is taken only once
// the last one is decoded and its result emitted; a waiting result does not block
// the next sample. Synchronous active-low reset returns the decoder to its start state,
// clears the step time and sets the maximum multiplier to one.
module quadrature_decoder_with_acceleration (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [qdec_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [qdec_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_a_level,
    input  logic                               s_b_level,
    input  logic [qdec_pkg::TIME_W-1:0]        s_now_ms,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [qdec_pkg::STEP_W-1:0] m_step_count
);
    import qdec_pkg::*;

    qdec_cmd_t cmd;
    qdec_sts_t sts;

    qdec_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    qdec_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_a_level    (s_a_level),
        .s_b_level    (s_b_level),
        .s_now_ms     (s_now_ms),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_step_count (m_step_count),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule
